>>> rtl/mcos_pkg.sv
// shared constants and types of the min-cost open set
`default_nettype none
package mcos_pkg;

  localparam int ENTRIES   = 64;
  localparam int NODE_BITS = 16;
  localparam int COST_BITS = 16;
  localparam int KEY_BITS  = COST_BITS + 1;
  localparam int AGE_BITS  = 16;
  localparam int IDX_BITS  = $clog2(ENTRIES);

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_POP = 1'b1;

  localparam logic [2:0] ST_ADDED   = 3'd0;
  localparam logic [2:0] ST_UPDATED = 3'd1;
  localparam logic [2:0] ST_POPPED  = 3'd2;
  localparam logic [2:0] ST_EMPTY   = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  typedef logic [NODE_BITS-1:0] node_t;
  typedef logic [COST_BITS-1:0] cost_t;
  typedef logic [KEY_BITS-1:0]  key_t;
  typedef logic [AGE_BITS-1:0]  age_t;
  typedef logic [IDX_BITS-1:0]  idx_t;

  // search token that walks the chain, one cell per cycle
  typedef struct packed {
    logic  valid;
    logic  op;
    node_t node;
    key_t  key;
    logic  found;
    idx_t  found_idx;
    logic  free_ok;
    idx_t  free_idx;
    logic  best_ok;
    idx_t  best_idx;
    key_t  best_key;
    age_t  best_dist;
    node_t best_node;
  } probe_t;

  // write or clear of one cell, broadcast to the whole row
  typedef struct packed {
    logic  wr;
    logic  clr;
    idx_t  idx;
    node_t node;
    key_t  key;
    age_t  age;
  } cmd_t;

endpackage
`default_nettype wire

>>> rtl/mcos_cell.sv
// one entry of the open set plus its stage of the search chain
`default_nettype none
module mcos_cell (
  input  wire               clk,
  input  wire               rst,
  input  mcos_pkg::idx_t    cell_idx,
  input  mcos_pkg::age_t    seq,
  input  mcos_pkg::cmd_t    cmd,
  input  mcos_pkg::probe_t  probe_in,
  output mcos_pkg::probe_t  probe_out
);
  import mcos_pkg::*;

  logic   valid;
  node_t  node;
  key_t   key;
  age_t   age;
  probe_t probe_next;
  age_t   age_gap;
  logic   better;

  assign age_gap = seq - age;
  assign better  = !probe_in.best_ok || (key < probe_in.best_key) ||
                   ((key == probe_in.best_key) && (age_gap > probe_in.best_dist));

  always_comb begin
    probe_next = probe_in;
    if (valid && (node == probe_in.node) && !probe_in.found) begin
      probe_next.found     = 1'b1;
      probe_next.found_idx = cell_idx;
    end
    if (!valid && !probe_in.free_ok) begin
      probe_next.free_ok  = 1'b1;
      probe_next.free_idx = cell_idx;
    end
    if (valid && better) begin
      probe_next.best_ok   = 1'b1;
      probe_next.best_idx  = cell_idx;
      probe_next.best_key  = key;
      probe_next.best_dist = age_gap;
      probe_next.best_node = node;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid           <= 1'b0;
      probe_out.valid <= 1'b0;
    end else begin
      probe_out.valid <= probe_next.valid;
      if (cmd.idx == cell_idx) begin
        if (cmd.wr) begin
          valid <= 1'b1;
        end else if (cmd.clr) begin
          valid <= 1'b0;
        end
      end
    end
    probe_out.op        <= probe_next.op;
    probe_out.node      <= probe_next.node;
    probe_out.key       <= probe_next.key;
    probe_out.found     <= probe_next.found;
    probe_out.found_idx <= probe_next.found_idx;
    probe_out.free_ok   <= probe_next.free_ok;
    probe_out.free_idx  <= probe_next.free_idx;
    probe_out.best_ok   <= probe_next.best_ok;
    probe_out.best_idx  <= probe_next.best_idx;
    probe_out.best_key  <= probe_next.best_key;
    probe_out.best_dist <= probe_next.best_dist;
    probe_out.best_node <= probe_next.best_node;
    if (cmd.wr && (cmd.idx == cell_idx)) begin
      node <= cmd.node;
      key  <= cmd.key;
      age  <= cmd.age;
    end
  end

endmodule
`default_nettype wire

>>> rtl/min_cost_open_set.sv
// top level of the min-cost open set: a row of entry cells and the commit logic
//
// Open set for a best-first search, one entry per node id, keyed by
// path_cost + estimate. An item is taken when start is high and busy is low;
// busy then stays high until its result appears. Each item sends a search
// token down the row of ENTRIES cells, one cell per cycle starting in the
// accepting cycle, and the add, update or pop is then committed from the token
// at the end of the row. The result is shown for one cycle with done high, and
// busy is already low in that cycle, so the next item can be taken at the edge
// that ends it. done cannot be held off, so the result must be captured in that
// cycle. A pop returns the least key, oldest add first on equal keys.
`default_nettype none
module min_cost_open_set (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  output logic                 busy,
  input  wire                  opcode,
  input  mcos_pkg::node_t      node_id,
  input  mcos_pkg::cost_t      path_cost,
  input  mcos_pkg::cost_t      estimate,
  output logic                 done,
  output mcos_pkg::node_t      out_node,
  output mcos_pkg::key_t       out_key,
  output logic [2:0]           status
);
  import mcos_pkg::*;

  probe_t             chain [0:ENTRIES];
  logic [ENTRIES:0]   chain_valid;
  probe_t             last;
  cmd_t               cmd;
  age_t               seq;
  logic [2:0]         status_next;
  logic               stored;

  always_comb begin
    chain[0]           = '0;
    chain[0].valid     = start && !busy;
    chain[0].op        = opcode;
    chain[0].node      = node_id;
    chain[0].key       = {1'b0, path_cost} + {1'b0, estimate};
  end

  genvar i;
  generate
    for (i = 0; i < ENTRIES; i++) begin : g_cell
      mcos_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .cell_idx  (IDX_BITS'(i)),
        .seq       (seq),
        .cmd       (cmd),
        .probe_in  (chain[i]),
        .probe_out (chain[i+1])
      );
    end
    for (i = 0; i <= ENTRIES; i++) begin : g_valid
      assign chain_valid[i] = chain[i].valid;
    end
  endgenerate

  assign last = chain[ENTRIES];

  always_comb begin
    cmd         = '0;
    cmd.node    = last.node;
    cmd.key     = last.key;
    cmd.age     = seq;
    status_next = ST_EMPTY;
    stored      = 1'b0;
    if (last.op == OP_POP) begin
      cmd.idx = last.best_idx;
      if (last.best_ok) begin
        cmd.clr     = last.valid;
        status_next = ST_POPPED;
      end
    end else if (last.found) begin
      cmd.idx     = last.found_idx;
      cmd.wr      = last.valid;
      stored      = 1'b1;
      status_next = ST_UPDATED;
    end else if (last.free_ok) begin
      cmd.idx     = last.free_idx;
      cmd.wr      = last.valid;
      stored      = 1'b1;
      status_next = ST_ADDED;
    end else begin
      status_next = ST_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      seq  <= '0;
    end else begin
      done <= last.valid;
      if (start && !busy) begin
        busy <= 1'b1;
      end else if (last.valid) begin
        busy <= 1'b0;
      end
      if (last.valid && stored) begin
        seq <= seq + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (last.valid) begin
      status <= status_next;
      if (status_next == ST_POPPED) begin
        out_node <= last.best_node;
        out_key  <= last.best_key;
      end else begin
        out_node <= '0;
        out_key  <= '0;
      end
    end
  end

  // at most one search token in flight
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(chain_valid))
    else $error("more than one search token in the chain");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("result strobe without a pending item");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after a transfer");

  a_busy_token: assert property (@(posedge clk) disable iff (rst)
    busy |-> ($countones(chain_valid[ENTRIES:1]) == 1))
    else $error("busy without a search token");

endmodule
`default_nettype wire

>>> bench/tb.sv
// testbench of the min-cost open set: a predictor-backed scoreboard checks each result
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mcos_pkg::*;

  localparam int RANDOM_ITEMS = 1200;
  localparam int POOL_SIZE    = 96;
  localparam int CYCLE_LIMIT  = 2_000_000;

  typedef struct packed {
    node_t      node;
    key_t       key;
    logic [2:0] status;
  } outcome_t;

  class open_set_tracker;
    bit       live [ENTRIES];
    node_t    held_node [ENTRIES];
    key_t     held_key [ENTRIES];
    age_t     held_age [ENTRIES];
    age_t     add_count;
    outcome_t owed [$];
    int       errors;

    function void flag(string what);
      errors++;
      if (errors <= 10) $display("mismatch: %s", what);
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function void note_transfer(logic op, node_t n, cost_t c, cost_t e);
      outcome_t want;
      key_t     k;
      key_t     best_key;
      age_t     age_gap;
      age_t     best_gap;
      int       hit;
      int       slot;
      int       best;
      want = '{node: '0, key: '0, status: ST_EMPTY};
      if (op == OP_ADD) begin
        k = key_t'(c) + key_t'(e);
        hit = -1;
        slot = -1;
        for (int i = 0; i < ENTRIES; i++)
          if (live[i] && held_node[i] == n && hit < 0) hit = i;
        if (hit >= 0) slot = hit;
        else
          for (int i = 0; i < ENTRIES; i++)
            if (!live[i] && slot < 0) slot = i;
        if (slot < 0) begin
          want.status = ST_FULL;
        end else begin
          live[slot] = 1'b1;
          held_node[slot] = n;
          held_key[slot] = k;
          held_age[slot] = add_count;
          add_count++;
          want.status = (hit >= 0) ? ST_UPDATED : ST_ADDED;
        end
      end else begin
        best = -1;
        best_key = '0;
        best_gap = '0;
        for (int i = 0; i < ENTRIES; i++) begin
          if (!live[i]) continue;
          age_gap = add_count - held_age[i];
          if (best < 0 || held_key[i] < best_key ||
              (held_key[i] == best_key && age_gap > best_gap)) begin
            best = i;
            best_key = held_key[i];
            best_gap = age_gap;
          end
        end
        if (best >= 0) begin
          live[best] = 1'b0;
          want = '{node: held_node[best], key: best_key, status: ST_POPPED};
        end
      end
      owed.push_back(want);
    endfunction

    function void check_transfer(node_t n, key_t k, logic [2:0] s);
      outcome_t want;
      if (owed.size() == 0) begin
        flag($sformatf("unexpected result node %h key %h status %0d", n, k, s));
        return;
      end
      want = owed.pop_front();
      if (n !== want.node || k !== want.key || s !== want.status)
        flag($sformatf("expected node %h key %h status %0d, got node %h key %h status %0d",
                       want.node, want.key, want.status, n, k, s));
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       opcode = OP_ADD;
  node_t      node_id = '0;
  cost_t      path_cost = '0;
  cost_t      estimate = '0;
  logic       busy;
  logic       done;
  node_t      out_node;
  key_t       out_key;
  logic [2:0] status;

  open_set_tracker tracker = new;
  node_t           pool [POOL_SIZE];
  int              cycle_count = 0;

  min_cost_open_set dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .opcode    (opcode),
    .node_id   (node_id),
    .path_cost (path_cost),
    .estimate  (estimate),
    .done      (done),
    .out_node  (out_node),
    .out_key   (out_key),
    .status    (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done === 1'b1) tracker.check_transfer(out_node, out_key, status);
      if (start && busy === 1'b0)
        tracker.note_transfer(opcode, node_id, path_cost, estimate);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic send(input logic op, input node_t n, input cost_t c, input cost_t e);
    start <= 1'b1;
    opcode <= op;
    node_id <= n;
    path_cost <= c;
    estimate <= e;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic hold_off(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_all_returned();
    start <= 1'b0;
    do @(negedge clk); while (tracker.pending() != 0);
    @(posedge clk);
  endtask

  function automatic cost_t pick_cost();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 5) return cost_t'($urandom_range(0, 3));
    if (roll < 8) return cost_t'($urandom_range(0, 255));
    return cost_t'($urandom);
  endfunction

  function automatic node_t pick_node();
    if ($urandom_range(0, 99) < 85) return pool[$urandom_range(0, POOL_SIZE - 1)];
    return node_t'($urandom);
  endfunction

  initial begin
    int sent;
    int burst;
    int mode;
    int len;
    int pop_pct;
    for (int i = 0; i < POOL_SIZE; i++) pool[i] = node_t'(($urandom & 16'hFF80) | i);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty pop, extreme fields, ties, updates to better and worse keys
    send(OP_POP, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send(OP_ADD, 16'h0000, 16'h0000, 16'h0000);
    send(OP_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send(OP_ADD, 16'h1234, 16'd5, 16'd5);
    send(OP_ADD, 16'h4321, 16'd10, 16'd0);
    send(OP_ADD, 16'h0AAA, 16'd0, 16'd10);
    send(OP_ADD, 16'h1234, 16'd3, 16'd7);
    send(OP_ADD, 16'h0000, 16'h8000, 16'h8000);
    send(OP_POP, 16'h0000, 16'h0000, 16'h0000);
    send(OP_POP, 16'hA5A5, 16'h5A5A, 16'hFFFF);
    send(OP_POP, 16'h0000, 16'h0000, 16'h0000);
    send(OP_ADD, 16'hFFFF, 16'd1, 16'd0);
    send(OP_ADD, 16'h5555, 16'd0, 16'd1);
    send(OP_POP, 16'h0000, 16'h0000, 16'h0000);
    send(OP_POP, 16'h0000, 16'h0000, 16'h0000);
    send(OP_POP, 16'h0000, 16'h0000, 16'h0000);
    send(OP_POP, 16'h0000, 16'h0000, 16'h0000);
    send(OP_POP, 16'h0000, 16'h0000, 16'h0000);
    send(OP_ADD, 16'hA5A5, 16'hFFFF, 16'h0000);
    send(OP_ADD, 16'h5A5A, 16'h0000, 16'hFFFF);
    send(OP_POP, 16'hFFFF, 16'h0000, 16'h0000);
    send(OP_POP, 16'h0000, 16'hFFFF, 16'hFFFF);
    wait_all_returned();

    sent = 0;
    burst = 0;
    while (sent < RANDOM_ITEMS) begin
      mode = (burst == 0) ? 0 : $urandom_range(0, 11);
      if (mode == 0) begin
        // flood with every distinct pool node, more than the store can hold
        for (int k = 0; k < POOL_SIZE; k++) send(OP_ADD, pool[k], pick_cost(), pick_cost());
        sent += POOL_SIZE;
      end else begin
        pop_pct = (mode < 5) ? 15 : (mode < 8) ? 80 : 50;
        len = $urandom_range(1, 40);
        for (int j = 0; j < len; j++) begin
          if ($urandom_range(0, 99) < pop_pct)
            send(OP_POP, node_t'($urandom), cost_t'($urandom), cost_t'($urandom));
          else
            send(OP_ADD, pick_node(), pick_cost(), pick_cost());
        end
        sent += len;
      end
      burst++;
      if ($urandom_range(0, 14) == 0) wait_all_returned();
      else if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 20));
    end

    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (ENTRIES + 8) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule
`default_nettype wire
